// ===== rtl/uvsph_pkg.sv =====
// Shared types and constants for the UV sphere vertex and face generator.
package uvsph_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    // Limits on the ring and stack counts
    localparam logic [10:0] MAX_SLICES = 11'd1024;
    localparam logic [10:0] MAX_STACKS = 11'd1024;

    // Output fraction bits and the rounding shift down from Q30
    localparam int FRAC_BITS = 16;
    localparam int RND_SH    = 30 - FRAC_BITS;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Reciprocals ceil(2^42 / d) for the Taylor term divisors
    localparam int RCP_SH = 42;
    localparam logic [41:0] SIN_M [8] = '{
        42'((64'd4398046511104 + 64'd5)   / 64'd6),
        42'((64'd4398046511104 + 64'd19)  / 64'd20),
        42'((64'd4398046511104 + 64'd41)  / 64'd42),
        42'((64'd4398046511104 + 64'd71)  / 64'd72),
        42'((64'd4398046511104 + 64'd109) / 64'd110),
        42'((64'd4398046511104 + 64'd155) / 64'd156),
        42'((64'd4398046511104 + 64'd209) / 64'd210),
        42'((64'd4398046511104 + 64'd271) / 64'd272)
    };
    localparam logic [41:0] COS_M [8] = '{
        42'((64'd4398046511104 + 64'd1)   / 64'd2),
        42'((64'd4398046511104 + 64'd11)  / 64'd12),
        42'((64'd4398046511104 + 64'd29)  / 64'd30),
        42'((64'd4398046511104 + 64'd55)  / 64'd56),
        42'((64'd4398046511104 + 64'd89)  / 64'd90),
        42'((64'd4398046511104 + 64'd131) / 64'd132),
        42'((64'd4398046511104 + 64'd181) / 64'd182),
        42'((64'd4398046511104 + 64'd239) / 64'd240)
    };

    // Request description carried down the pipeline
    typedef struct packed {
        logic        func;
        logic        bad;
        logic        top;
        logic        bot;
        logic        body;
        logic [20:0] cur;
        logic [20:0] nxt;
        logic [20:0] dn;
        logic [20:0] dnx;
    } t_meta;

    // Phase divider state for both angles
    typedef struct packed {
        logic [11:0] rp;
        logic [11:0] rt;
        logic [31:0] qp;
        logic [31:0] qt;
    } t_div;

    // Taylor series state for one angle
    typedef struct packed {
        logic [1:0]         quad;
        logic [31:0]        x2;
        logic [32:0]        ts;
        logic [32:0]        tc;
        logic signed [33:0] s;
        logic signed [33:0] c;
    } t_trig;

    // Signed sine and cosine as magnitude and negative flag
    typedef struct packed {
        logic [30:0] sm;
        logic        sn;
        logic [30:0] cm;
        logic        cn;
    } t_sc;

endpackage

// ===== rtl/uv_sphere_vertex_face_generator_core.sv =====
// Pipelined UV sphere vertex and face generator.
// Pipeline: 55 stages and one output register. Throughput: one request per cycle for vertex
// and error requests while the output is not stalled; a face request holds the output
// register until its triangles (up to three) have all passed the single result port.
// A stall at the output freezes every stage at once. Synchronous active-low reset clears
// valid bits and loads radius 1 and counts 8; no memories to clear.
module uv_sphere_vertex_face_generator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // stack_index[10:0], slice_index[20:11], zero pad
    input  logic         i_s_axis_tuser,   // func
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [159:0] o_m_axis_tdata,   // pos_x, pos_y, pos_z, corner_first, corner_second,
                                           // corner_third, status (lowest first)
    output logic         o_m_axis_tlast,   // last
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [14:0]  i_cfg_data
);

    localparam int LAST = 54;

    logic [14:0] r_radius;
    logic [10:0] r_slices;
    logic [10:0] r_stacks;

    logic [LAST:0]     r_vld;
    uvsph_pkg::t_meta  r_mt [0:LAST];
    uvsph_pkg::t_div   r_dv [0:32];
    logic [1:0]        r_xq [0:1];
    logic [30:0]       r_xv [0:1];
    uvsph_pkg::t_trig  r_sr [0:16][0:1];
    uvsph_pkg::t_sc    r_sc [0:1];
    logic [30:0]       r_m  [0:2];
    logic              r_ng [0:2];
    logic [32:0]       r_v  [0:2];
    logic              r_vn [0:2];
    logic [31:0]       r_p  [0:2];

    logic              r_ov;
    uvsph_pkg::t_meta  r_omt;
    logic [31:0]       r_opos [0:2];
    logic [1:0]        r_idx;

    logic              en;
    logic [1:0]        res_cnt;
    logic              out_last;
    uvsph_pkg::t_meta  fr_mt;
    uvsph_pkg::t_div   fr_dv;

    // One restoring step of both phase divisions
    function automatic uvsph_pkg::t_div div_step(input uvsph_pkg::t_div a,
                                                 input logic [11:0] dp,
                                                 input logic [11:0] dt);
        uvsph_pkg::t_div o;
        logic [12:0] sp;
        logic [12:0] st;
        o  = a;
        sp = {a.rp, 1'b0};
        st = {a.rt, 1'b0};
        if (sp >= {1'b0, dp}) begin
            o.rp = 12'(sp - {1'b0, dp});
            o.qp = {a.qp[30:0], 1'b1};
        end else begin
            o.rp = sp[11:0];
            o.qp = {a.qp[30:0], 1'b0};
        end
        if (st >= {1'b0, dt}) begin
            o.rt = 12'(st - {1'b0, dt});
            o.qt = {a.qt[30:0], 1'b1};
        end else begin
            o.rt = st[11:0];
            o.qt = {a.qt[30:0], 1'b0};
        end
        return o;
    endfunction

    // One half-term of the sine and cosine series: product on even steps,
    // reciprocal divide and accumulate on odd steps
    function automatic uvsph_pkg::t_trig ser_step(input uvsph_pkg::t_trig a, input int kk);
        uvsph_pkg::t_trig o;
        logic [64:0] ps;
        logic [64:0] pc;
        logic [74:0] qs;
        logic [74:0] qc;
        int i;
        o  = a;
        i  = kk >> 1;
        ps = 65'(a.ts) * 65'(a.x2);
        pc = 65'(a.tc) * 65'(a.x2);
        qs = 75'(a.ts) * 75'(uvsph_pkg::SIN_M[i]);
        qc = 75'(a.tc) * 75'(uvsph_pkg::COS_M[i]);
        if ((kk & 1) == 0) begin
            o.ts = ps[62:30];
            o.tc = pc[62:30];
        end else begin
            o.ts = qs[uvsph_pkg::RCP_SH +: 33];
            o.tc = qc[uvsph_pkg::RCP_SH +: 33];
            if ((i & 1) == 0) begin
                o.s = a.s - $signed({1'b0, o.ts});
                o.c = a.c - $signed({1'b0, o.tc});
            end else begin
                o.s = a.s + $signed({1'b0, o.ts});
                o.c = a.c + $signed({1'b0, o.tc});
            end
        end
        return o;
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
        logic [30:0] r;
        if (v < 0) r = '0;
        else if (v > $signed({3'b000, uvsph_pkg::Q30_ONE})) r = uvsph_pkg::Q30_ONE;
        else r = v[30:0];
        return r;
    endfunction

    // Fold the first-quadrant values by the quadrant bits
    function automatic uvsph_pkg::t_sc fold_quad(input uvsph_pkg::t_trig a);
        uvsph_pkg::t_sc o;
        logic [30:0] s;
        logic [30:0] c;
        s = clamp_unit(a.s);
        c = clamp_unit(a.c);
        case (a.quad)
            2'd0: o = '{sm: s, sn: 1'b0, cm: c, cn: 1'b0};
            2'd1: o = '{sm: c, sn: 1'b0, cm: s, cn: (s != '0)};
            2'd2: o = '{sm: s, sn: (s != '0), cm: c, cn: (c != '0)};
            default: o = '{sm: c, sn: (c != '0), cm: s, cn: 1'b0};
        endcase
        return o;
    endfunction

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 15'd1;
            r_slices <= 11'd8;
            r_stacks <= 11'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                uvsph_pkg::REG_RADIUS: r_radius <= i_cfg_data;
                uvsph_pkg::REG_SLICES: r_slices <= i_cfg_data[10:0];
                uvsph_pkg::REG_STACKS: r_stacks <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Decode the request: range check, cell corners, divider start
    always_comb begin
        logic [10:0] st;
        logic [9:0]  sl;
        logic [21:0] base;
        logic [10:0] sl1;
        logic [21:0] cur;
        logic [21:0] nxt;
        st   = i_s_axis_tdata[10:0];
        sl   = i_s_axis_tdata[20:11];
        base = 22'(st) * 22'(r_slices);
        sl1  = 11'(sl) + 11'd1;
        if (sl1 == r_slices) sl1 = '0;
        cur  = base + 22'(sl);
        nxt  = base + 22'(sl1);
        fr_mt.func = i_s_axis_tuser;
        fr_mt.bad  = (r_slices == '0) || (r_stacks == '0) ||
                     (r_slices > uvsph_pkg::MAX_SLICES) ||
                     (r_stacks > uvsph_pkg::MAX_STACKS) || ({1'b0, sl} >= r_slices) ||
                     (i_s_axis_tuser ? (st >= r_stacks) : (st > r_stacks));
        fr_mt.top  = (st == '0);
        fr_mt.bot  = (st == 11'(r_stacks - 11'd1));
        fr_mt.body = (12'(st) + 12'd1 < 12'(r_stacks));
        fr_mt.cur  = cur[20:0];
        fr_mt.nxt  = nxt[20:0];
        fr_mt.dn   = 21'(cur + 22'(r_slices));
        fr_mt.dnx  = 21'(nxt + 22'(r_slices));
        fr_dv.rp   = {1'b0, st};
        fr_dv.rt   = {2'b00, sl};
        fr_dv.qp   = '0;
        fr_dv.qt   = '0;
    end

    // Results of the item in the output register
    always_comb begin
        if (r_omt.bad || !r_omt.func) res_cnt = 2'd1;
        else res_cnt = 2'({1'b0, r_omt.top | r_omt.bot} + {r_omt.body, 1'b0});
    end
    assign out_last = (r_idx == 2'(res_cnt - 2'd1));
    assign en       = !r_ov || (i_m_axis_tready && out_last);
    assign o_s_axis_tready = en;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_s_axis_tvalid};
        end
    end

    // Advance the payload of every stage together
    always_ff @(posedge i_clk) begin
        logic [60:0] px;
        logic [61:0] pq;
        logic [61:0] pm;
        logic [46:0] pr;
        if (en) begin
            r_mt[0] <= fr_mt;
            r_dv[0] <= fr_dv;
            for (int i = 1; i <= LAST; i++) r_mt[i] <= r_mt[i-1];
            for (int i = 1; i <= 32; i++)
                r_dv[i] <= div_step(r_dv[i-1], {r_stacks, 1'b0}, {1'b0, r_slices});
            // reduced angle in Q30 radians
            for (int a = 0; a < 2; a++) begin
                logic [31:0] ph;
                ph = (a == 0) ? r_dv[32].qp : r_dv[32].qt;
                px = 61'(ph[29:0]) * 61'(uvsph_pkg::HALF_PI_Q30);
                r_xq[a] <= ph[31:30];
                r_xv[a] <= px[60:30];
            end
            // square and series start
            for (int a = 0; a < 2; a++) begin
                pq = 62'(r_xv[a]) * 62'(r_xv[a]);
                r_sr[0][a].quad <= r_xq[a];
                r_sr[0][a].x2   <= pq[61:30];
                r_sr[0][a].ts   <= 33'(r_xv[a]);
                r_sr[0][a].tc   <= 33'(uvsph_pkg::Q30_ONE);
                r_sr[0][a].s    <= 34'(r_xv[a]);
                r_sr[0][a].c    <= 34'(uvsph_pkg::Q30_ONE);
            end
            for (int k = 1; k <= 16; k++)
                for (int a = 0; a < 2; a++)
                    r_sr[k][a] <= ser_step(r_sr[k-1][a], k - 1);
            for (int a = 0; a < 2; a++) r_sc[a] <= fold_quad(r_sr[16][a]);
            // magnitude products rounded to Q30
            pm = 62'(r_sc[0].sm) * 62'(r_sc[1].cm) + 62'(1) * 62'(31'h2000_0000);
            r_m[0]  <= pm[60:30];
            r_ng[0] <= r_sc[0].sn ^ r_sc[1].cn;
            r_m[1]  <= r_sc[0].cm;
            r_ng[1] <= r_sc[0].cn;
            pm = 62'(r_sc[0].sm) * 62'(r_sc[1].sm) + 62'(31'h2000_0000);
            r_m[2]  <= pm[60:30];
            r_ng[2] <= r_sc[0].sn ^ r_sc[1].sn;
            // radius scale, rounded to output fraction bits
            for (int j = 0; j < 3; j++) begin
                pr = 47'(r_radius) * 47'(r_m[j]) + (47'(1) << (uvsph_pkg::RND_SH - 1));
                r_v[j]  <= 33'(pr >> uvsph_pkg::RND_SH);
                r_vn[j] <= r_ng[j];
            end
            // saturate and apply the sign
            for (int j = 0; j < 3; j++) begin
                if (r_vn[j]) begin
                    if (r_v[j] > 33'h0_8000_0000) r_p[j] <= 32'h8000_0000;
                    else r_p[j] <= 32'(-r_v[j]);
                end else begin
                    if (r_v[j] > 33'h0_7FFF_FFFF) r_p[j] <= 32'h7FFF_FFFF;
                    else r_p[j] <= r_v[j][31:0];
                end
            end
        end
    end

    // Output register: hold one item and step through its triangles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else if (en) begin
            r_ov  <= r_vld[LAST];
            r_idx <= '0;
        end else if (i_m_axis_tready) begin
            r_idx <= 2'(r_idx + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_omt <= r_mt[LAST];
            for (int j = 0; j < 3; j++) r_opos[j] <= r_p[j];
        end
    end

    // Assemble the result
    always_comb begin
        logic [1:0]  k;
        logic [20:0] c1;
        logic [20:0] c2;
        logic [20:0] c3;
        k = (r_omt.top | r_omt.bot) ? r_idx : 2'(r_idx + 2'd1);
        case (k)
            2'd0: begin
                c1 = r_omt.cur;
                c2 = r_omt.top ? r_omt.nxt : r_omt.dn;
                c3 = r_omt.top ? r_omt.dn : r_omt.nxt;
            end
            2'd1: begin
                c1 = r_omt.cur;
                c2 = r_omt.dn;
                c3 = r_omt.nxt;
            end
            default: begin
                c1 = r_omt.nxt;
                c2 = r_omt.dn;
                c3 = r_omt.dnx;
            end
        endcase
        o_m_axis_tdata = '0;
        if (r_omt.bad) begin
            o_m_axis_tdata[159] = 1'b1;
        end else if (!r_omt.func) begin
            o_m_axis_tdata[95:0] = {r_opos[2], r_opos[1], r_opos[0]};
        end else begin
            o_m_axis_tdata[158:96] = {c3, c2, c1};
        end
    end
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = out_last;

    // Triangle counter never passes the item's result count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_idx < res_cnt)) else $error("triangle index past result count");
    // An error result is always the only one
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_omt.bad) |-> out_last) else $error("error result not last");
    // A stall freezes the valid bits of every stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld)) else $error("pipeline moved during stall");

endmodule

// ===== tb/uv_sphere_vertex_face_generator_core_tb.sv =====
// Self-checking testbench for the UV sphere vertex and face generator core.
`timescale 1ns / 1ps

module uv_sphere_vertex_face_generator_core_tb;

    localparam int DRAIN_CYCLES = 64;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 35;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    // One result as seen on the master side
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [20:0]        c1;
        logic [20:0]        c2;
        logic [20:0]        c3;
        logic               status;
        logic               last;
    } t_mesh_res;

    // Directed stimulus row; a fixed row carries its single expected result
    typedef struct {
        bit          fn;
        int          st;
        int          sl;
        bit          fixed;
        bit          est;
        logic [31:0] ey;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [23:0]  i_s_axis_tdata = '0;
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [159:0] o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [14:0]  i_cfg_data = '0;

    uv_sphere_vertex_face_generator_core uut (.*);

    always #5 i_clk = ~i_clk;

    // Mirror of the configuration registers
    logic [14:0] mdl_radius = 15'd1;
    logic [10:0] mdl_slices = 11'd8;
    logic [10:0] mdl_stacks = 11'd8;

    t_mesh_res pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    int  stall_left = 0;

    // Append one expected result at the tail of the queue
    function automatic void queue_result(t_mesh_res r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Pick a gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sine and cosine in Q30 from a 32-bit phase
    task automatic phase_sin_cos(input logic [31:0] phase, output longint sn,
                                 output longint cs);
        longint unsigned f, x, x2, ts, tc;
        longint s, c;
        f  = phase[29:0];
        x  = (f * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1073741824;
        s  = x;
        c  = 64'd1073741824;
        for (int k = 1; k <= 8; k++) begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s -= ts;
                c -= tc;
            end else begin
                s += ts;
                c += tc;
            end
        end
        if (s < 0) s = 0;
        if (s > 64'd1073741824) s = 64'd1073741824;
        if (c < 0) c = 0;
        if (c > 64'd1073741824) c = 64'd1073741824;
        case (phase[31:30])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    // Radius times two Q30 factors, rounded to the output fraction, saturated
    function automatic logic [31:0] scaled_coord(longint a, longint b);
        bit neg;
        longint unsigned ma, mb, m, v;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        m   = (ma * mb + (64'd1 << 29)) >> 30;
        v   = (longint'(mdl_radius) * m + (64'd1 << (uvsph_pkg::RND_SH - 1)))
              >> uvsph_pkg::RND_SH;
        if (neg) begin
            if (v > 64'h8000_0000) v = 64'h8000_0000;
            return 32'(-v);
        end
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic t_mesh_res tri_res(longint unsigned a, longint unsigned b,
                                          longint unsigned c);
        t_mesh_res r;
        r = '{default: '0};
        r.c1 = a[20:0];
        r.c2 = b[20:0];
        r.c3 = c[20:0];
        return r;
    endfunction

    // Work out and queue the results of one accepted request
    task automatic sphere_cell_answers(bit fn, logic [10:0] st, logic [9:0] sl);
        longint unsigned s_n, t_n, cur, nxt, dn, dnx;
        longint sp, cp, sth, cth;
        bit bad;
        t_mesh_res r;
        t_mesh_res tris[$];
        s_n = mdl_slices;
        t_n = mdl_stacks;
        bad = s_n == 0 || t_n == 0 || s_n > uvsph_pkg::MAX_SLICES ||
              t_n > uvsph_pkg::MAX_STACKS || sl >= s_n;
        if (!bad) bad = fn ? (st >= t_n) : (st > t_n);
        r = '{default: '0};
        if (bad) begin
            r.status = 1'b1;
            r.last = 1'b1;
            queue_result(r);
        end else if (!fn) begin
            phase_sin_cos(32'((longint'(st) << 31) / t_n), sp, cp);
            phase_sin_cos(32'((longint'(sl) << 32) / s_n), sth, cth);
            r.px = scaled_coord(sp, cth);
            r.py = scaled_coord(cp, 64'd1073741824);
            r.pz = scaled_coord(sp, sth);
            r.last = 1'b1;
            queue_result(r);
        end else begin
            cur = st * s_n + sl;
            nxt = st * s_n + (sl + 1) % s_n;
            dn  = cur + s_n;
            dnx = nxt + s_n;
            if (st == 0) tris.insert(tris.size(), tri_res(cur, nxt, dn));
            else if (st == t_n - 1) tris.insert(tris.size(), tri_res(cur, dn, nxt));
            if (st + 1 < t_n) begin
                tris.insert(tris.size(), tri_res(cur, dn, nxt));
                tris.insert(tris.size(), tri_res(nxt, dn, dnx));
            end
            tris[tris.size() - 1].last = 1'b1;
            foreach (tris[i]) queue_result(tris[i]);
        end
    endtask

    // Offer one request and hold it until accepted
    task automatic send_request(bit fn, logic [10:0] st, logic [9:0] sl, bit fixed,
                                bit est, logic [31:0] ey);
        int gap;
        t_mesh_res r;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= fn;
        i_s_axis_tdata  <= {3'b000, sl, st};
        do @(posedge i_clk); while (!o_s_axis_tready);
        requests_sent++;
        if (fixed) begin
            r = '{default: '0};
            r.py = ey;
            r.status = est;
            r.last = 1'b1;
            queue_result(r);
        end else begin
            sphere_cell_answers(fn, st, sl);
        end
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain_pipe();
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            uvsph_pkg::REG_RADIUS: mdl_radius = val;
            uvsph_pkg::REG_SLICES: mdl_slices = val[10:0];
            uvsph_pkg::REG_STACKS: mdl_stacks = val[10:0];
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Drive the result side ready with random stalls
    always @(negedge i_clk) begin
        int p;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (calm || p < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                stall_left <= (p < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_mesh_res got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.px = o_m_axis_tdata[31:0];
            got.py = o_m_axis_tdata[63:32];
            got.pz = o_m_axis_tdata[95:64];
            got.c1 = o_m_axis_tdata[116:96];
            got.c2 = o_m_axis_tdata[137:117];
            got.c3 = o_m_axis_tdata[158:138];
            got.status = o_m_axis_tdata[159];
            got.last = o_m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
                    got.c1 !== want.c1 || got.c2 !== want.c2 || got.c3 !== want.c3 ||
                    got.status !== want.status || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p actual %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    // Watchdog: stop when no handshake moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_dir_row rows[16];
        logic [14:0] cfg_sets[10][3];
        logic [10:0] st;
        logic [9:0]  sl;
        int t_span, s_span;
        bit fn;

        // Under reset values: radius 1, eight slices, eight stacks
        rows = '{
            '{0, 0,    0,    1, 0, 32'h0001_0000},  // top pole
            '{0, 8,    0,    1, 0, 32'hFFFF_0000},  // bottom pole
            '{0, 9,    0,    1, 1, 32'h0},          // stack past the pole
            '{0, 0,    8,    1, 1, 32'h0},          // slice out of range
            '{1, 8,    0,    1, 1, 32'h0},          // face stack out of range
            '{1, 2047, 1023, 1, 1, 32'h0},          // all index bits high
            '{0, 2047, 0,    1, 1, 32'h0},
            '{0, 3,    1023, 1, 1, 32'h0},
            '{1, 0,    7,    0, 0, 32'h0},          // top cap with wrap
            '{1, 0,    0,    0, 0, 32'h0},
            '{1, 3,    7,    0, 0, 32'h0},          // body
            '{1, 7,    7,    0, 0, 32'h0},          // bottom cap
            '{0, 4,    2,    0, 0, 32'h0},
            '{0, 2,    5,    0, 0, 32'h0},
            '{0, 6,    7,    0, 0, 32'h0},
            '{0, 1,    3,    0, 0, 32'h0}
        };
        cfg_sets = '{
            '{15'd32767, 15'd1024, 15'd1024},
            '{15'd0,     15'd8,    15'd8},
            '{15'd100,   15'd1,    15'd1},
            '{15'd5,     15'd16,   15'd12},
            '{15'd32767, 15'd7,    15'd3},
            '{15'd12345, 15'd0,    15'd8},     // zero slices
            '{15'd3,     15'd1025, 15'd2047},  // counts too large
            '{15'd77,    15'd6,    15'd0},     // zero stacks
            '{15'd1,     15'd1024, 15'd2},
            '{15'd2000,  15'd33,   15'd1023}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (rows[i])
            send_request(rows[i].fn, rows[i].st[10:0], rows[i].sl[9:0], rows[i].fixed,
                         rows[i].est, rows[i].ey);
        drain_pipe();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(uvsph_pkg::REG_RADIUS, cfg_sets[ph][0]);
            write_reg(uvsph_pkg::REG_SLICES, cfg_sets[ph][1]);
            write_reg(uvsph_pkg::REG_STACKS, cfg_sets[ph][2]);
            if (ph == 4) write_reg(REG_UNMAPPED, 15'h7FFF);
            calm = (ph % 3 == 2);
            t_span = (mdl_stacks == 0 || mdl_stacks > uvsph_pkg::MAX_STACKS) ? 8 : mdl_stacks;
            s_span = (mdl_slices == 0 || mdl_slices > uvsph_pkg::MAX_SLICES) ? 8 : mdl_slices;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                fn = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 85) begin
                    st = 11'($urandom_range(0, t_span));
                    sl = 10'($urandom_range(0, s_span - 1));
                end else begin
                    st = 11'($urandom);
                    sl = 10'($urandom);
                end
                send_request(fn, st, sl, 1'b0, 1'b0, 32'h0);
            end
            drain_pipe();
        end

        $display("Covered %0d requests and %0d results over reset values and ten settings,",
                 requests_sent, results_seen);
        $display("including pole, cap, wrap and out-of-range cases under random stalls.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/uvsph_pkg.sv
rtl/uv_sphere_vertex_face_generator_core.sv
tb/uv_sphere_vertex_face_generator_core_tb.sv
